>>> hdl/gsa_pkg.sv
// Shared types, codes and field widths for the generational slot allocator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package gsa_pkg;

    // Payload field widths
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned GEN_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LIMIT_W  = 9;
    localparam int unsigned DATA_W   = INDEX_W + GEN_W;

    // Table depth default and limit register reset value
    localparam int unsigned SLOT_COUNT_DEF = 256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // Operation codes carried in the input tuser
    localparam logic [MODE_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] OP_LOOKUP  = 3'd2;
    localparam logic [MODE_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [MODE_W-1:0] OP_REL_ALL = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_LIMIT   = 2'd3;

    // Write enables into the slot table
    typedef struct packed {
        logic gen;
        logic occ;
        logic stk;
    } tbl_we_t;

    // Output of the shared generation check/bump unit
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GEN_W-1:0]    bumped;
    } chk_t;

endpackage

>>> hdl/gsa_table.sv
// Slot table storage: generation, occupancy and free-stack memories.
// One write and one registered read port per memory; uses gsa_pkg.
module gsa_table #(
    parameter int unsigned SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    localparam int unsigned IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic                      aclk,
    input  gsa_pkg::tbl_we_t          we,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [IDX_W-1:0]          rd_addr,
    input  logic [gsa_pkg::GEN_W-1:0] gen_wdata,
    input  logic                      occ_wdata,
    input  logic [IDX_W-1:0]          stk_wr_addr,
    input  logic [IDX_W-1:0]          stk_rd_addr,
    input  logic [IDX_W-1:0]          stk_wdata,
    output logic [gsa_pkg::GEN_W-1:0] gen_rdata,
    output logic                      occ_rdata,
    output logic [IDX_W-1:0]          stk_rdata
);

    logic [gsa_pkg::GEN_W-1:0] gen_mem [SLOT_COUNT];
    logic                      occ_mem [SLOT_COUNT];
    logic [IDX_W-1:0]          stk_mem [SLOT_COUNT];

    logic [gsa_pkg::GEN_W-1:0] gen_rd_reg;
    logic                      occ_rd_reg;
    logic [IDX_W-1:0]          stk_rd_reg;

    // Generation and occupancy share the slot address
    always_ff @(posedge aclk) begin
        if (we.gen) begin
            gen_mem[wr_addr] <= gen_wdata;
        end
        if (we.occ) begin
            occ_mem[wr_addr] <= occ_wdata;
        end
        gen_rd_reg <= gen_mem[rd_addr];
        occ_rd_reg <= occ_mem[rd_addr];
    end

    // Free stack of released slot indices
    always_ff @(posedge aclk) begin
        if (we.stk) begin
            stk_mem[stk_wr_addr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_rd_addr];
    end

    assign gen_rdata = gen_rd_reg;
    assign occ_rdata = occ_rd_reg;
    assign stk_rdata = stk_rd_reg;

endmodule

>>> hdl/gsa_gen_unit.sv
// Shared generation unit: handle match check and generation bump (0 skipped).
// Used by release, lookup and the release-all walk; uses gsa_pkg.
module gsa_gen_unit (
    input  logic [gsa_pkg::GEN_W-1:0] rd_gen,
    input  logic                      rd_occ,
    input  logic [gsa_pkg::GEN_W-1:0] hgen,
    output gsa_pkg::chk_t             chk
);

    logic [gsa_pkg::GEN_W-1:0] inc;

    // Bump wraps past zero straight to one
    assign inc = rd_gen + gsa_pkg::GEN_W'(1);
    assign chk.bumped = (inc == '0) ? gsa_pkg::GEN_W'(1) : inc;

    // Unoccupied slot or wrong generation makes the handle stale
    assign chk.status = (rd_occ && (rd_gen == hgen)) ? gsa_pkg::STAT_OK
                                                     : gsa_pkg::STAT_STALE;

endmodule

>>> hdl/generational_slot_allocator_unit.sv
// Generational slot allocator top level: sequencer, control registers, output stage.
// Depends on gsa_pkg, gsa_table and gsa_gen_unit.
//
// Usage: a request enters on the s_ stream (tuser = mode, tdata = index and
// generation) and exactly one result leaves on the m_ stream (tuser = status,
// tdata = index and generation). slot_limit is written on the cfg_ channel,
// which is always ready; write it only while no request is in flight.
// Path from accepted request to result: clear, limit failure, invalid handle
// and allocate of a new slot go from execute straight to output; release and
// lookup add a check state; allocate from the free stack adds pop and
// generation states; release-all reads and writes each slot below the
// high-water mark. A new request is taken only once the sequencer is idle
// again, after the result is loaded, so requests do not overlap. The extra
// states wait on the single registered read port of each table memory.
// A result waiting on a stalled receiver does not block the next request;
// that request runs and holds in its output state until the stage frees.
// Reset clears the high-water mark, the free stack and the output valid and
// restores slot_limit to 256; table contents need no clearing pass.
module generational_slot_allocator_unit #(
    parameter int unsigned SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gsa_pkg::DATA_W-1:0]    s_tdata,  // [7:0] slot_index, [39:8] handle_generation
    input  logic [gsa_pkg::MODE_W-1:0]    s_tuser,  // [2:0] mode
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsa_pkg::DATA_W-1:0]    m_tdata,  // [7:0] result_index, [39:8] result_generation
    output logic [gsa_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gsa_pkg::LIMIT_W-1:0]   cfg_data  // [8:0] slot_limit
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int unsigned LIM_W = (CNT_W > gsa_pkg::LIMIT_W) ? CNT_W : gsa_pkg::LIMIT_W;
    localparam int unsigned IR_W  = (CNT_W > gsa_pkg::INDEX_W) ? CNT_W : gsa_pkg::INDEX_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_A_POP   = 3'd2;
    localparam logic [2:0] ST_A_GEN   = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_WALK_RD = 3'd5;
    localparam logic [2:0] ST_WALK_WR = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    // Control state
    logic [2:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               hwm_reg, hwm_next;
    logic [CNT_W-1:0]               depth_reg, depth_next;
    logic [gsa_pkg::LIMIT_W-1:0]    limit_reg;
    logic                           m_valid_reg, m_valid_next;

    // Payload registers
    logic [gsa_pkg::MODE_W-1:0]     op_reg, op_next;
    logic [gsa_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic [gsa_pkg::GEN_W-1:0]      hgen_reg, hgen_next;
    logic [IDX_W-1:0]               slot_reg, slot_next;
    logic [CNT_W-1:0]               walk_reg, walk_next;
    logic [gsa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [gsa_pkg::INDEX_W-1:0]    res_index_reg, res_index_next;
    logic [gsa_pkg::GEN_W-1:0]      res_gen_reg, res_gen_next;
    logic [gsa_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [gsa_pkg::DATA_W-1:0]     m_data_reg, m_data_next;

    // Table interface
    gsa_pkg::tbl_we_t               tbl_we;
    logic [IDX_W-1:0]               wr_addr, rd_addr, stk_wr_addr, stk_rd_addr, stk_wdata;
    logic [gsa_pkg::GEN_W-1:0]      gen_wdata, gen_rdata;
    logic                           occ_wdata, occ_rdata;
    logic [IDX_W-1:0]               stk_rdata;
    gsa_pkg::chk_t                  chk;

    // Helpers
    logic [LIM_W-1:0]               limit_eff;
    logic                           can_grow, handle_bad, out_free, do_push;
    logic [IDX_W-1:0]               push_slot, idx_slot;
    logic [CNT_W-1:0]               depth_dec;

    gsa_table #(.SLOT_COUNT(SLOT_COUNT)) u_table (
        .aclk        (aclk),
        .we          (tbl_we),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .gen_wdata   (gen_wdata),
        .occ_wdata   (occ_wdata),
        .stk_wr_addr (stk_wr_addr),
        .stk_rd_addr (stk_rd_addr),
        .stk_wdata   (stk_wdata),
        .gen_rdata   (gen_rdata),
        .occ_rdata   (occ_rdata),
        .stk_rdata   (stk_rdata)
    );

    gsa_gen_unit u_gen (
        .rd_gen (gen_rdata),
        .rd_occ (occ_rdata),
        .hgen   (hgen_reg),
        .chk    (chk)
    );

    // Effective limit is min(slot_limit, SLOT_COUNT)
    assign limit_eff  = (LIM_W'(limit_reg) < LIM_W'(SLOT_COUNT)) ? LIM_W'(limit_reg)
                                                                  : LIM_W'(SLOT_COUNT);
    assign can_grow   = LIM_W'(hwm_reg) < limit_eff;
    assign handle_bad = (hgen_reg == '0) || (IR_W'(idx_reg) >= IR_W'(hwm_reg));
    assign idx_slot   = IDX_W'(idx_reg);
    assign depth_dec  = depth_reg - CNT_W'(1);
    assign out_free   = !m_valid_reg || m_tready;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_status_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        hwm_next        = hwm_reg;
        depth_next      = depth_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        hgen_next       = hgen_reg;
        slot_next       = slot_reg;
        walk_next       = walk_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        tbl_we          = '0;
        wr_addr         = '0;
        rd_addr         = '0;
        gen_wdata       = '0;
        occ_wdata       = 1'b0;
        stk_rd_addr     = '0;
        do_push         = 1'b0;
        push_slot       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    idx_next   = s_tdata[gsa_pkg::INDEX_W-1:0];
                    hgen_next  = s_tdata[gsa_pkg::DATA_W-1:gsa_pkg::INDEX_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_status_next = gsa_pkg::STAT_OK;
                res_index_next  = '0;
                res_gen_next    = '0;
                state_next      = ST_OUT;
                unique case (op_reg)
                    gsa_pkg::OP_ALLOC: begin
                        if (depth_reg != '0) begin
                            // reuse most recently freed slot
                            stk_rd_addr = depth_dec[IDX_W-1:0];
                            depth_next  = depth_dec;
                            state_next  = ST_A_POP;
                        end else if (can_grow) begin
                            // fresh slot at the high-water mark
                            tbl_we.gen     = 1'b1;
                            tbl_we.occ     = 1'b1;
                            wr_addr        = hwm_reg[IDX_W-1:0];
                            gen_wdata      = gsa_pkg::GEN_W'(1);
                            occ_wdata      = 1'b1;
                            res_index_next = gsa_pkg::INDEX_W'(hwm_reg);
                            res_gen_next   = gsa_pkg::GEN_W'(1);
                            hwm_next       = hwm_reg + CNT_W'(1);
                        end else begin
                            res_status_next = gsa_pkg::STAT_LIMIT;
                        end
                    end
                    gsa_pkg::OP_RELEASE, gsa_pkg::OP_LOOKUP: begin
                        if (handle_bad) begin
                            res_status_next = gsa_pkg::STAT_INVALID;
                        end else begin
                            rd_addr    = idx_slot;
                            state_next = ST_CHECK;
                        end
                    end
                    gsa_pkg::OP_CLEAR: begin
                        hwm_next   = '0;
                        depth_next = '0;
                    end
                    gsa_pkg::OP_REL_ALL: begin
                        walk_next  = '0;
                        state_next = ST_WALK_RD;
                    end
                    default: begin
                    end
                endcase
            end
            ST_A_POP: begin
                slot_next  = stk_rdata;
                rd_addr    = stk_rdata;
                state_next = ST_A_GEN;
            end
            ST_A_GEN: begin
                tbl_we.occ      = 1'b1;
                wr_addr         = slot_reg;
                occ_wdata       = 1'b1;
                res_status_next = gsa_pkg::STAT_OK;
                res_index_next  = gsa_pkg::INDEX_W'(slot_reg);
                res_gen_next    = gen_rdata;
                state_next      = ST_OUT;
            end
            ST_CHECK: begin
                state_next = ST_OUT;
                if (chk.status != gsa_pkg::STAT_OK) begin
                    res_status_next = chk.status;
                end else begin
                    res_status_next = gsa_pkg::STAT_OK;
                    res_index_next  = idx_reg;
                    if (op_reg == gsa_pkg::OP_RELEASE) begin
                        tbl_we.gen   = 1'b1;
                        tbl_we.occ   = 1'b1;
                        wr_addr      = idx_slot;
                        gen_wdata    = chk.bumped;
                        occ_wdata    = 1'b0;
                        do_push      = 1'b1;
                        push_slot    = idx_slot;
                        res_gen_next = chk.bumped;
                    end else begin
                        res_gen_next = gen_rdata;
                    end
                end
            end
            ST_WALK_RD: begin
                if (walk_reg < hwm_reg) begin
                    rd_addr    = walk_reg[IDX_W-1:0];
                    state_next = ST_WALK_WR;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_WALK_WR: begin
                // free each occupied slot in ascending order
                if (occ_rdata) begin
                    tbl_we.gen = 1'b1;
                    tbl_we.occ = 1'b1;
                    wr_addr    = walk_reg[IDX_W-1:0];
                    gen_wdata  = chk.bumped;
                    occ_wdata  = 1'b0;
                    do_push    = 1'b1;
                    push_slot  = walk_reg[IDX_W-1:0];
                end
                walk_next  = walk_reg + CNT_W'(1);
                state_next = ST_WALK_RD;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = {res_gen_reg, res_index_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Free-stack push for release and release-all
        tbl_we.stk = 1'b0;
        if (do_push && (depth_reg < CNT_W'(SLOT_COUNT))) begin
            tbl_we.stk = 1'b1;
            depth_next = depth_reg + CNT_W'(1);
        end
    end

    assign stk_wr_addr = depth_reg[IDX_W-1:0];
    assign stk_wdata   = push_slot;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hwm_reg     <= '0;
            depth_reg   <= '0;
            limit_reg   <= gsa_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hwm_reg     <= hwm_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        hgen_reg       <= hgen_next;
        slot_reg       <= slot_next;
        walk_reg       <= walk_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
    end

`ifndef ASSERT_OFF
    // Free stack never holds more slots than were ever handed out
    a_depth_le_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= hwm_reg)
        else $error("free stack deeper than high-water mark");

    // High-water mark stays within the table
    a_hwm_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= CNT_W'(SLOT_COUNT))
        else $error("high-water mark beyond table depth");

    // An accepted request starts execution on the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execution");

    // A finished result waits while the output stage is occupied
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result overwrote a pending transaction");

    // Failed requests carry an all-zero payload
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != gsa_pkg::STAT_OK)) |-> (m_data_reg == '0))
        else $error("failed result with nonzero payload");
`endif

endmodule
